### rtl/core/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants for the CSR sparse matrix-vector block.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COL_W   = 12;
    localparam int CCNT_W  = 13;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 64;
    localparam int ROW_W   = 16;

    localparam logic [CCNT_W-1:0] COLUMN_COUNT_RST = 13'd4096;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_NONZERO = 2'd1,
        MODE_EMPTY   = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                   mode;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] element_value;
        logic                    last_in_row;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_result;
        logic [ROW_W-1:0]        row_index;
        logic                    index_error;
    } out_item_t;

    // Work descriptor handed from front end to back end.
    typedef struct packed {
        mode_t            mode;
        logic [VAL_W-1:0] value;     // sign-extended matrix value
        logic [VAL_W-1:0] x;         // sign-extended vector entry
        logic             in_range;
        logic             last;
    } op_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

### rtl/core/csm_fifo.sv
// ----------------------------------------------------------------------------
// csm_fifo
// Short work queue between the front end and the back end.
// ----------------------------------------------------------------------------
module csm_fifo #(
    parameter int DEPTH = csm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  csm_pkg::op_t                 push_op,
    input  logic                         pop,
    output csm_pkg::op_t                 head_op,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    csm_pkg::op_t   slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op = slot_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign fill    = count_reg;

    // front end credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

### rtl/core/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front
// Input side: takes transfers, keeps the vector store and the column
// count, checks column range and queues work for the back end.
// ----------------------------------------------------------------------------
module csm_front #(
    parameter int MAX_COLUMNS = csm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_BITS  = csm_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = csm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  csm_pkg::in_item_t                   in_item,
    input  logic                                cfg_we,
    input  logic [csm_pkg::CCNT_W-1:0]          cfg_wdata,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_fill,
    output logic                                q_push,
    output csm_pkg::op_t                        q_op
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH+1);
    localparam logic [16:0] MAXC = 17'(MAX_COLUMNS);

    logic [VALUE_BITS-1:0]          vec_mem_reg [MAX_COLUMNS];
    logic [VALUE_BITS-1:0]          x_reg;
    logic [csm_pkg::CCNT_W-1:0]     column_count_reg;

    logic                           s1_valid_reg;
    csm_pkg::mode_t                 s1_mode_reg;
    logic [VALUE_BITS-1:0]          s1_value_reg;
    logic                           s1_range_reg;
    logic                           s1_last_reg;

    logic                           in_fire;
    logic [16:0]                    col_wide;
    logic [AW-1:0]                  addr;
    logic                           col_in_store;
    logic                           col_in_range;
    logic [QW:0]                    used;

    assign col_wide     = 17'(in_item.column);
    assign addr         = col_wide[AW-1:0];
    assign col_in_store = (col_wide < MAXC);
    assign col_in_range = col_in_store && (col_wide < 17'(column_count_reg));

    // credit: every item in flight must find a queue slot
    assign used     = (QW+1)'(q_fill) + (QW+1)'(s1_valid_reg);
    assign in_ready = (used < (QW+1)'(QUEUE_DEPTH));
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= csm_pkg::COLUMN_COUNT_RST;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                column_count_reg <= cfg_wdata;
            end
            s1_valid_reg <= in_fire && (in_item.mode != csm_pkg::MODE_LOAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg  <= in_item.mode;
            s1_value_reg <= in_item.element_value[VALUE_BITS-1:0];
            s1_range_reg <= col_in_range;
            s1_last_reg  <= in_item.last_in_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_item.mode == csm_pkg::MODE_LOAD) && col_in_store)
        begin
            vec_mem_reg[addr] <= in_item.element_value[VALUE_BITS-1:0];
        end
        if (in_fire && (in_item.mode == csm_pkg::MODE_NONZERO))
        begin
            x_reg <= vec_mem_reg[addr];
        end
    end

    always_comb
    begin
        q_push          = s1_valid_reg;
        q_op.mode       = s1_mode_reg;
        q_op.value      = csm_pkg::VAL_W'($signed(s1_value_reg));
        q_op.x          = csm_pkg::VAL_W'($signed(x_reg));
        q_op.in_range   = s1_range_reg;
        q_op.last       = s1_last_reg;
    end

    a_load_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_item.mode == csm_pkg::MODE_LOAD)) |=> !s1_valid_reg)
        else $error("vector load reached the work queue");

endmodule

### rtl/core/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back
// Execution side: multiply stage, saturating row accumulator, row
// bookkeeping and the output register.
// ----------------------------------------------------------------------------
module csm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  csm_pkg::op_t        q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output csm_pkg::out_item_t  out_item
);

    localparam int AW = csm_pkg::ACC_W;

    // multiply stage
    logic                       a_valid_reg;
    csm_pkg::mode_t             a_mode_reg;
    logic signed [AW-1:0]       a_prod_reg;
    logic                       a_range_reg;
    logic                       a_last_reg;

    // row state
    logic signed [AW-1:0]               acc_reg, acc_next;
    logic                               err_reg, err_next;
    logic [csm_pkg::ROW_W-1:0]          row_reg, row_next;

    logic                       out_valid_reg, out_valid_next;
    csm_pkg::out_item_t         out_item_reg, out_item_next;

    logic                       adv;
    logic                       emit;
    logic signed [AW-1:0]       prod;
    logic signed [AW-1:0]       sum;
    logic signed [AW-1:0]       sat_sum;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = !q_empty && (!a_valid_reg || adv);
    assign prod  = $signed(q_head.value) * $signed(q_head.x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_mode_reg  <= csm_pkg::MODE_LOAD;
        end
        else
        begin
            if (!a_valid_reg || adv)
            begin
                a_valid_reg <= q_pop;
            end
            if (q_pop)
            begin
                a_mode_reg <= q_head.mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_prod_reg  <= q_head.in_range ? prod : '0;
            a_range_reg <= q_head.in_range;
            a_last_reg  <= q_head.last;
        end
    end

    // saturating add of the product into the row sum
    always_comb
    begin
        sum = acc_reg + a_prod_reg;
        if ((acc_reg[AW-1] == a_prod_reg[AW-1]) && (sum[AW-1] != acc_reg[AW-1]))
        begin
            sat_sum = acc_reg[AW-1] ? csm_pkg::ACC_MIN : csm_pkg::ACC_MAX;
        end
        else
        begin
            sat_sum = sum;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        err_next  = err_reg;
        row_next  = row_reg;
        emit      = 1'b0;
        out_item_next.row_result  = '0;
        out_item_next.row_index   = row_reg;
        out_item_next.index_error = 1'b0;
        unique case (a_mode_reg)
            csm_pkg::MODE_NONZERO:
            begin
                acc_next = a_range_reg ? sat_sum : acc_reg;
                err_next = err_reg || !a_range_reg;
                if (a_last_reg)
                begin
                    emit = 1'b1;
                    out_item_next.row_result  = acc_next;
                    out_item_next.index_error = err_next;
                    acc_next = '0;
                    err_next = 1'b0;
                    row_next = row_reg + 1'b1;
                end
            end
            csm_pkg::MODE_EMPTY:
            begin
                emit     = 1'b1;
                acc_next = '0;
                err_next = 1'b0;
                row_next = row_reg + 1'b1;
            end
            csm_pkg::MODE_RESTART:
            begin
                acc_next = '0;
                err_next = 1'b0;
                row_next = '0;
            end
            csm_pkg::MODE_LOAD:
            begin
                // loads never reach the back end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = a_valid_reg && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (a_valid_reg && adv)
            begin
                acc_reg <= acc_next;
                err_reg <= err_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && adv && emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !adv) |=> (a_valid_reg && $stable(a_prod_reg)))
        else $error("multiply stage lost its item under stall");

    a_empty_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && adv && (a_mode_reg == csm_pkg::MODE_EMPTY))
        |=> (out_valid_reg && (out_item_reg.row_result == '0)
             && !out_item_reg.index_error))
        else $error("empty row did not give a zero result");

endmodule

### rtl/core/csr_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// Sparse matrix times dense vector, compressed-row form, fixed point.
// ----------------------------------------------------------------------------
// Load the vector first (mode load, one entry per transfer), then stream the
// nonzeros row by row; the nonzero marked last in its row, or an empty-row
// transfer, gives one result with the Q32.32 saturated row sum and the row
// index. The block takes one transfer per cycle in steady state; a result
// passes the front-end register, queue and multiply stage. Input ready is set
// by a credit on the four-entry work queue, so a stalled output stops
// acceptance once the queue and the multiply stage have filled. The column
// count register must be written only while no work is in flight.
// ----------------------------------------------------------------------------
module csr_sparse_matvec #(
    parameter int MAX_COLUMNS = csm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_BITS  = csm_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = csm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  csm_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output csm_pkg::out_item_t          out_item,
    input  logic                        cfg_we,
    input  logic [csm_pkg::CCNT_W-1:0]  cfg_wdata
);

    logic                               q_push;
    logic                               q_pop;
    logic                               q_empty;
    csm_pkg::op_t                       q_in_op;
    csm_pkg::op_t                       q_head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_fill;

    csm_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_BITS  (VALUE_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_fill    (q_fill),
        .q_push    (q_push),
        .q_op      (q_in_op)
    );

    csm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in_op),
        .pop     (q_pop),
        .head_op (q_head),
        .empty   (q_empty),
        .fill    (q_fill)
    );

    csm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
